// File: sv/box_average_3x3_stride2_unit_macros.svh
// Assertion macros used by the checker file of the box average unit.
`ifndef BOX_AVERAGE_3X3_STRIDE2_UNIT_MACROS_SVH
`define BOX_AVERAGE_3X3_STRIDE2_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define BAV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bav: assertion failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define BAV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bav: assertion failed");

`endif

// File: sv/bav_pkg.sv
// Types and fixed constants of the box average unit.
package bav_pkg;

   localparam int PIXEL_W    = 16;
   localparam int AVG_W      = 16;
   localparam int CFG_W      = 11;
   localparam int SIZE_RESET = 1024;
   localparam int SIZE_MIN   = 2;
   localparam int ROW_SUM_W  = 18;
   localparam int ACC_W      = 20;

   // floor(s / 9) == (s * DIV9_RECIP) >> DIV9_SHIFT for every s below 2**20
   localparam int RECIP_W    = 20;
   localparam int DIV9_SHIFT = 23;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'(932068);
   localparam int PROD_W     = ACC_W + RECIP_W;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0] average;
      logic             last_of_image;
   } rsp_type;

endpackage

// File: sv/bav_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bav_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/box_average_3x3_stride2_unit.sv
// Top level of the 3x3 box average with 2x downsampling.
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-------------------------------
//   req      | in        | req_valid / req_stall  | req_type: pixel, frame_start
//   rsp      | out       | rsp_valid / rsp_stall  | rsp_type: average, last_of_image
//   csr      | in        | csr_wr_en              | image_size, 11 bits
//
// One pixel is taken every cycle while no result beat is held. A result follows
// its window's last pixel through column-memory read, window sum, divide by nine.
// A stalled result beat freezes all three stages, and req_stall follows it.
// Reset is synchronous; both column memories start undefined and need no sweep.
module box_average_3x3_stride2_unit
   import bav_pkg::*;
#(
   parameter int MAX_SIZE = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int PW       = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
   localparam int SW       = $clog2(MAX_SIZE + 1);
   localparam int HALF     = (MAX_SIZE + 1) / 2;
   localparam int AW       = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int SIZE_RST = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;

   // configuration
   logic [SW-1:0] size_ff, size_in;

   always_comb begin
      if (csr_wr_data < CFG_W'(SIZE_MIN)) begin
         size_in = SW'(SIZE_MIN);
      end else if (32'(csr_wr_data) > 32'(MAX_SIZE)) begin
         size_in = SW'(MAX_SIZE);
      end else begin
         size_in = SW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SW'(SIZE_RST);
      end else if (csr_wr_en) begin
         size_ff <= size_in;
      end
   end

   // pipeline control: every stage moves unless the output beat is held
   logic advance;
   logic accept;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // stage 0: position and horizontal triple
   logic [PW-1:0]        col_ff, col_in, row_ff, row_in;
   logic [ROW_SUM_W-1:0] hpart_ff, hpart_in;
   logic [PIXEL_W-1:0]   shared_pix_ff, shared_pix_in;
   logic [PW-1:0]        x, y;
   logic                 restart, x_last, y_last, x_odd;
   logic                 hdone;
   logic [ROW_SUM_W-1:0] hsum;
   logic [AW-1:0]        col_addr;

   always_comb begin
      restart = req_payload.frame_start || (SW'(row_ff) >= size_ff)
                || (SW'(col_ff) >= size_ff);
      x        = restart ? '0 : col_ff;
      y        = restart ? '0 : row_ff;
      x_last   = (SW'(x) == size_ff - SW'(1));
      y_last   = (SW'(y) == size_ff - SW'(1));
      x_odd    = x[0];
      col_addr = AW'(x >> 1);

      hpart_in      = hpart_ff;
      shared_pix_in = shared_pix_ff;
      if (!x_odd) begin
         hpart_in = ((x == '0) ? '0 : ROW_SUM_W'(shared_pix_ff))
                    + ROW_SUM_W'(req_payload.pixel);
         hsum     = hpart_in;
         hdone    = x_last;
      end else begin
         hsum          = hpart_ff + ROW_SUM_W'(req_payload.pixel);
         shared_pix_in = req_payload.pixel;
         hdone         = 1'b1;
      end

      // advance position, wrap at the image end
      if (x_last) begin
         col_in = '0;
         row_in = y_last ? '0 : y + PW'(1);
      end else begin
         col_in = x + PW'(1);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         hpart_ff      <= '0;
         shared_pix_ff <= '0;
      end else if (accept) begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         hpart_ff      <= hpart_in;
         shared_pix_ff <= shared_pix_in;
      end
   end

   // stage 1: column memories read in flight
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_hdone_ff;
   logic                 s1_y_zero_ff;
   logic                 s1_y_odd_ff;
   logic                 s1_y_last_ff;
   logic                 s1_end_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic [ROW_SUM_W-1:0] s1_hsum_ff;

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hdone_ff  <= hdone;
         s1_y_zero_ff <= (y == '0);
         s1_y_odd_ff  <= y[0];
         s1_y_last_ff <= y_last;
         s1_end_ff    <= x_last && y_last;
         s1_addr_ff   <= col_addr;
         s1_hsum_ff   <= hsum;
      end
   end

   // Two windows that share a column entry are at least two pixels apart, so
   // a write from stage 1 never meets a read of the same entry that is used.
   logic [ROW_SUM_W-1:0] row_sum_rd;
   logic [ACC_W-1:0]     acc_rd;
   logic                 row_sum_we, acc_we;
   logic [ACC_W-1:0]     vert_sum;
   logic [ACC_W-1:0]     total;
   logic                 emit;

   always_comb begin
      vert_sum   = (s1_y_zero_ff ? '0 : ACC_W'(row_sum_rd)) + ACC_W'(s1_hsum_ff);
      emit       = s1_valid_ff && s1_hdone_ff && (s1_y_odd_ff || s1_y_last_ff);
      total      = s1_y_odd_ff ? (acc_rd + ACC_W'(s1_hsum_ff)) : vert_sum;
      acc_we     = s1_valid_ff && advance && s1_hdone_ff && !s1_y_odd_ff
                   && !s1_y_last_ff;
      row_sum_we = s1_valid_ff && advance && s1_hdone_ff && s1_y_odd_ff;
   end

   bav_ram #(
      .WIDTH (ROW_SUM_W),
      .DEPTH (HALF)
   ) u_row_sum_ram (
      .clock   (clock),
      .wr_en   (row_sum_we),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_hsum_ff),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (row_sum_rd)
   );

   bav_ram #(
      .WIDTH (ACC_W),
      .DEPTH (HALF)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (s1_addr_ff),
      .wr_data (vert_sum),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (acc_rd)
   );

   // stage 2: window sum
   logic             s2_valid_ff;
   logic [ACC_W-1:0] s2_sum_ff;
   logic             s2_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff <= total;
         s2_end_ff <= s1_end_ff;
      end
   end

   // output register: divide by nine through the reciprocal
   logic [PROD_W-1:0] product;
   logic              out_valid_ff;
   rsp_type           out_ff, out_in;

   always_comb begin
      product              = PROD_W'(s2_sum_ff) * PROD_W'(DIV9_RECIP);
      out_in.average       = product[DIV9_SHIFT +: AVG_W];
      out_in.last_of_image = s2_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// File: sv/bav_checker.sv
// Port-level checker of the box average unit and its bind.
`include "box_average_3x3_stride2_unit_macros.svh"

module bav_checker
   import bav_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // a held result beat keeps its payload
   `BAV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // input is held back only by a held result beat
   `BAV_ASSERT_IMPL(a_req_free, clock, reset, !rsp_stall, !req_stall)

   `BAV_ASSERT_IMPL(a_req_held, clock, reset, rsp_valid && rsp_stall, req_stall)

   // nothing can leave in the first cycle out of reset
   `BAV_ASSERT_IMPL(a_rsp_after_reset, clock, reset, $fell(reset), !rsp_valid)

endmodule

bind box_average_3x3_stride2_unit bav_checker u_bav_checker (.*);

// File: tb/box_average_3x3_stride2_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 box average unit with 2x downsampling.
module box_average_3x3_stride2_unit_tb;
   import bav_pkg::*;

   localparam int MAX_SIZE      = 1024;
   localparam int HALF_DEPTH    = MAX_SIZE / 2;
   localparam int WINDOW_PIXELS = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 650;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_payload;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en;
   logic [CFG_W-1:0]   csr_wr_data;

   // Shadow of the block: size register, raster position and column stores
   logic [CFG_W-1:0]     size_setting;
   int unsigned          row_pos;
   int unsigned          col_pos;
   logic [ROW_SUM_W-1:0] row_sum_store [HALF_DEPTH];
   logic [ACC_W-1:0]     window_store [HALF_DEPTH];
   logic [ROW_SUM_W-1:0] pair_sum;
   logic [PIXEL_W-1:0]   odd_column_pixel;
   bit                   restart_needed;

   rsp_type pending_averages [$];
   int      error_count   = 0;
   int      items_sent    = 0;
   int      send_gap_max  = 0;
   int      stall_gap_max = 0;
   int      hold_count    = 0;

   box_average_3x3_stride2_unit #(
      .MAX_SIZE(MAX_SIZE)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned effective_size();
      if (size_setting < CFG_W'(SIZE_MIN)) return SIZE_MIN;
      if (size_setting > CFG_W'(MAX_SIZE)) return MAX_SIZE;
      return 32'(size_setting);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   // Advance the shadow by one pixel and queue the average it completes, if any
   task automatic predict_window_average(input logic [PIXEL_W-1:0] pix, input logic start);
      int unsigned          n, x, y, c;
      logic [ROW_SUM_W-1:0] hsum;
      logic [ACC_W-1:0]     vsum;
      logic [ACC_W-1:0]     total;
      bit                   hdone;
      bit                   emit;
      rsp_type              beat;
      n = effective_size();
      hsum = '0;
      total = '0;
      hdone = 1'b0;
      emit = 1'b0;
      if (start || row_pos >= n || col_pos >= n) begin
         row_pos = 0;
         col_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      c = (x / 2) % HALF_DEPTH;
      if (x % 2 == 0) begin
         pair_sum = ((x == 0) ? ROW_SUM_W'(0) : ROW_SUM_W'(odd_column_pixel))
                    + ROW_SUM_W'(pix);
         // right padding column of an odd size closes the triple early
         if (x == n - 1) begin
            hsum = pair_sum;
            hdone = 1'b1;
         end
      end else begin
         hsum = pair_sum + ROW_SUM_W'(pix);
         odd_column_pixel = pix;
         hdone = 1'b1;
      end
      if (hdone) begin
         if (y % 2 == 0) begin
            vsum = ((y == 0) ? ACC_W'(0) : ACC_W'(row_sum_store[c])) + ACC_W'(hsum);
            if (y == n - 1) begin
               total = vsum;
               emit = 1'b1;
            end else begin
               window_store[c] = vsum;
            end
         end else begin
            total = window_store[c] + ACC_W'(hsum);
            row_sum_store[c] = hsum;
            emit = 1'b1;
         end
      end
      beat.last_of_image = (x == n - 1) && (y == n - 1);
      if (x + 1 >= n) begin
         col_pos = 0;
         row_pos = (y + 1 >= n) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
      if (emit) begin
         beat.average = AVG_W'(total / WINDOW_PIXELS);
         pending_averages.push_back(beat);
      end
   endtask

   task automatic check_average(input rsp_type got);
      rsp_type want;
      if (pending_averages.size() == 0) begin
         report_mismatch($sformatf("unexpected beat: average %0d last %0b",
                                   got.average, got.last_of_image));
      end else begin
         want = pending_averages.pop_front();
         if (got.average !== want.average)
            report_mismatch($sformatf("average %0d, want %0d", got.average, want.average));
         if (got.last_of_image !== want.last_of_image)
            report_mismatch($sformatf("last_of_image %0b, want %0b",
                                      got.last_of_image, want.last_of_image));
      end
   endtask

   // Result side: check each beat, then hold stall for a random number of cycles
   always @(posedge clock) begin : result_side
      int unsigned wait_cycles;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_average(rsp_payload);
         wait_cycles = $urandom_range(stall_gap_max, 0);
         hold_count <= wait_cycles;
         rsp_stall <= (wait_cycles != 0);
      end else if (hold_count > 1) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else if (!rsp_valid && stall_gap_max != 0 && $urandom_range(7, 0) == 0) begin
         // stall ahead of the next beat too
         hold_count <= $urandom_range(stall_gap_max, 1);
         rsp_stall <= 1'b1;
      end else begin
         hold_count <= 0;
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic start);
      int unsigned gap;
      req_type     beat;
      beat.pixel = pix;
      beat.frame_start = start | restart_needed;
      restart_needed = 1'b0;
      gap = $urandom_range(send_gap_max, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      predict_window_average(beat.pixel, beat.frame_start);
      items_sent++;
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(7, 0))
         0:       return '1;
         1:       return '0;
         2:       return PIXEL_W'($urandom_range(65535, 65000));
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   task automatic send_frame(input int unsigned count, input bit with_start, input bit noisy);
      logic start;
      for (int unsigned i = 0; i < count; i++) begin
         start = (i == 0) ? with_start : (noisy && $urandom_range(199, 0) == 0);
         send_pixel(random_pixel(), start);
      end
   endtask

   // drop valid and hold until every expected beat is back; always wait on the clock
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_averages.size() != 0);
   endtask

   task automatic set_image_size(input logic [CFG_W-1:0] value);
      int unsigned old_size;
      drain_results();
      // let a pixel that closes no window clear the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
      old_size = effective_size();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_setting = value;
      // a wider image mid-frame would read columns never written: restart it
      if (effective_size() > old_size && (row_pos != 0 || col_pos != 0))
         restart_needed = 1'b1;
   endtask

   function automatic logic [CFG_W-1:0] random_size_value();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 5)  return CFG_W'($urandom_range(1, 0));
      if (pick < 75) return CFG_W'($urandom_range(10, 2));
      return CFG_W'($urandom_range(24, 11));
   endfunction

   task automatic test_reset_size();
      send_gap_max = 2;
      stall_gap_max = 2;
      // first half row at the reset size, then sizes above the range mid-row;
      // the windows of row 1 show that the width stayed at the largest size
      send_frame(MAX_SIZE / 2, 1, 0);
      set_image_size(CFG_W'(1025));
      send_frame(MAX_SIZE / 2 + 4, 0, 0);
      set_image_size(CFG_W'(2047));
      send_frame(4, 0, 0);
   endtask

   task automatic test_extremes();
      send_gap_max = 0;
      stall_gap_max = 0;
      set_image_size(CFG_W'(3));
      for (int i = 0; i < 9; i++) send_pixel('1, i == 0);
      // wrap into a second image without a frame start
      for (int i = 0; i < 9; i++) send_pixel('0, 1'b0);
      set_image_size(CFG_W'(0));
      for (int i = 0; i < 4; i++) send_pixel('1, i == 0);
   endtask

   task automatic test_size_clamp();
      send_gap_max = 12;
      stall_gap_max = 12;
      set_image_size(CFG_W'(1));
      send_frame(4, 1, 0);
      send_frame(4, 0, 0);
      send_gap_max = 3;
      stall_gap_max = 3;
      set_image_size(CFG_W'(1025));
      send_frame(8, 1, 0);
      set_image_size(CFG_W'(2047));
      send_frame(8, 0, 0);
   endtask

   task automatic test_position_rules();
      send_gap_max = 5;
      stall_gap_max = 5;
      // column 16 falls outside a size of 8: the next pixel starts a new image
      set_image_size(CFG_W'(8));
      send_frame(20, 0, 0);
      // row 2 column 4 still lies inside a size of 6: carry on
      set_image_size(CFG_W'(6));
      send_frame(20 + 36, 0, 0);
      // abandon an image part way and restart it
      send_frame(5, 1, 0);
      send_frame(36, 1, 0);
   endtask

   task automatic test_random_frames();
      int unsigned first_item;
      int unsigned n;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         stall_gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         case ($urandom_range(9, 0))
            0, 1:    set_image_size(random_size_value());
            2:       drain_results();
            default: ;
         endcase
         n = effective_size();
         case ($urandom_range(9, 0))
            7:       send_frame(n * n, 0, 0);
            8:       send_frame($urandom_range(n * n - 1, 1), 1, 0);
            9:       send_frame(n * n, 1, 1);
            default: send_frame(n * n, 1, 0);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      size_setting = CFG_W'(SIZE_RESET);
      row_pos = 0;
      col_pos = 0;
      pair_sum = '0;
      odd_column_pixel = '0;
      restart_needed = 1'b0;
      for (int i = 0; i < HALF_DEPTH; i++) begin
         row_sum_store[i] = '0;
         window_store[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_size();
      test_extremes();
      test_size_clamp();
      test_position_rules();
      test_random_frames();
      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending_averages.size() != 0)
         report_mismatch($sformatf("%0d averages never arrived", pending_averages.size()));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: box_average_3x3_stride2_unit.f
+incdir+sv
sv/bav_pkg.sv
sv/bav_ram.sv
sv/box_average_3x3_stride2_unit.sv
sv/bav_checker.sv
tb/box_average_3x3_stride2_unit_tb.sv
